@@ hdl/i2cm_pkg.sv @@
// Shared types and constants for the I2C master bit sequencer.
`default_nettype none

package i2cm_pkg;

   localparam int DELAY_WIDTH_DEFAULT = 16;
   localparam int HALF_PERIOD_WIDTH   = 16;
   localparam logic [HALF_PERIOD_WIDTH-1:0] HALF_PERIOD_RESET = 16'd500;

   // APB register map: index bit of the byte address
   localparam int PADDR_WIDTH = 3;
   localparam int PDATA_WIDTH = 32;
   localparam logic REG_HALF_PERIOD = 1'b0;

   // command codes
   localparam logic [2:0] FUNC_NONE      = 3'd0;
   localparam logic [2:0] FUNC_START     = 3'd1;
   localparam logic [2:0] FUNC_WRITE     = 3'd2;
   localparam logic [2:0] FUNC_READ_ACK  = 3'd3;
   localparam logic [2:0] FUNC_READ_NAK  = 3'd4;
   localparam logic [2:0] FUNC_STOP      = 3'd5;

   typedef struct packed {
      logic       scl_level;
      logic       sda_pull_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       nack;
   } rsp_type;

endpackage

`default_nettype wire

@@ hdl/i2c_master_bit_sequencer.sv @@
// I2C master bit sequencer: top level with bit timer, line sequencer and result buffer.
`default_nettype none

// One input item is one tick of the bit timer and returns exactly one result item that
// shows the SCL/SDA drive, busy, the done pulse, the last read byte and the last nack.
// An item is taken every cycle while req_stall is low; the sequencer state is updated
// and the result registered at the edge that accepts it. A two-entry result buffer
// (output register plus skid register) lets one more item in while a result is stalled;
// req_stall rises only when both entries are full. Commands arriving while a command is
// in progress are ignored. Each line phase lasts half_period items (at least one), with
// half_period taken modulo 2**DELAY_WIDTH.
module i2c_master_bit_sequencer
   import i2cm_pkg::*;
#(
   parameter int DELAY_WIDTH = DELAY_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // input items
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [2:0]             req_func,
   input  wire logic [7:0]             req_data,
   input  wire logic                   req_sda_in,
   // result items
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_scl_level,
   output logic                        rsp_sda_pull_low,
   output logic                        rsp_busy_res,
   output logic                        rsp_done_res,
   output logic [7:0]                  rsp_read_byte,
   output logic                        rsp_nack,
   // configuration
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [PADDR_WIDTH-1:0] paddr,
   input  wire logic [PDATA_WIDTH-1:0] pwdata,
   output logic [PDATA_WIDTH-1:0]      prdata,
   output logic                        pready
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_REL   = 4'd1;
   localparam logic [3:0] ST_SCLH  = 4'd2;
   localparam logic [3:0] ST_SDAL  = 4'd3;
   localparam logic [3:0] ST_SCLL  = 4'd4;
   localparam logic [3:0] ST_BLOW  = 4'd5;
   localparam logic [3:0] ST_BHIGH = 4'd6;
   localparam logic [3:0] ST_ALOW  = 4'd7;
   localparam logic [3:0] ST_AHIGH = 4'd8;
   localparam logic [3:0] ST_TAIL  = 4'd9;
   localparam logic [3:0] ST_PLOW  = 4'd10;
   localparam logic [3:0] ST_PHIGH = 4'd11;
   localparam logic [3:0] ST_PREL  = 4'd12;

   localparam int HP_EXT_WIDTH =
      (DELAY_WIDTH > HALF_PERIOD_WIDTH) ? DELAY_WIDTH : HALF_PERIOD_WIDTH;

   // configuration
   logic [HALF_PERIOD_WIDTH-1:0] half_period_ff;
   logic                         cfg_wr;
   logic [HP_EXT_WIDTH-1:0]      hp_ext;
   logic [DELAY_WIDTH-1:0]       phase_len;

   // sequencer state
   logic [3:0]             step_ff, step_in;
   logic [3:0]             bit_count_ff, bit_count_in;
   logic [7:0]             shift_ff, shift_in;
   logic [DELAY_WIDTH-1:0] delay_ff, delay_in;
   logic [2:0]             cmd_ff, cmd_in;
   logic                   nack_ff, nack_in;
   logic [7:0]             rx_byte_ff, rx_byte_in;
   logic                   scl_ff, scl_in;
   logic                   sda_low_ff, sda_low_in;

   logic                   do_enter;
   logic [3:0]             enter_step;
   logic                   done;
   logic                   rd_cmd;
   logic [DELAY_WIDTH-1:0] delay_dec;
   logic [3:0]             bit_inc;

   // result buffer
   rsp_type res;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   logic    accept;
   logic    out_free;

   // ---------------- configuration port ----------------
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_HALF_PERIOD);

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
      end else if (cfg_wr) begin
         half_period_ff <= pwdata[HALF_PERIOD_WIDTH-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_HALF_PERIOD) begin
         prdata = PDATA_WIDTH'(half_period_ff);
      end
   end

   assign hp_ext    = HP_EXT_WIDTH'(half_period_ff);
   assign phase_len = (hp_ext[DELAY_WIDTH-1:0] == '0) ? DELAY_WIDTH'(1)
                                                       : hp_ext[DELAY_WIDTH-1:0];

   // ---------------- sequencer ----------------
   assign accept    = req_valid && !req_stall;
   assign delay_dec = delay_ff - DELAY_WIDTH'(1);
   assign bit_inc   = bit_count_ff + 4'd1;

   always_comb begin
      step_in      = step_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      delay_in     = delay_ff;
      cmd_in       = cmd_ff;
      nack_in      = nack_ff;
      rx_byte_in   = rx_byte_ff;
      do_enter     = 1'b0;
      enter_step   = ST_IDLE;
      done         = 1'b0;

      if (step_ff == ST_IDLE || step_ff > ST_PREL) begin
         if (req_func >= FUNC_START && req_func <= FUNC_STOP) begin
            cmd_in       = req_func;
            bit_count_in = 4'd0;
            shift_in     = (req_func == FUNC_START || req_func == FUNC_WRITE) ? req_data
                                                                              : 8'd0;
            do_enter     = 1'b1;
            if (req_func == FUNC_START) begin
               enter_step = ST_REL;
            end else if (req_func == FUNC_STOP) begin
               enter_step = ST_PLOW;
            end else begin
               enter_step = ST_BLOW;
            end
         end else begin
            step_in = ST_IDLE;
         end
      end else begin
         delay_in = delay_dec;
         if (delay_dec == '0) begin
            do_enter = 1'b1;
            case (step_ff)
               ST_REL:   enter_step = ST_SCLH;
               ST_SCLH:  enter_step = ST_SDAL;
               ST_SDAL:  enter_step = ST_SCLL;
               ST_SCLL: begin
                  bit_count_in = 4'd0;
                  enter_step   = ST_BLOW;
               end
               ST_BLOW:  enter_step = ST_BHIGH;
               ST_BHIGH: begin
                  shift_in     = {shift_ff[6:0], rd_cmd & req_sda_in};
                  bit_count_in = bit_inc;
                  enter_step   = (bit_inc >= 4'd8) ? ST_ALOW : ST_BLOW;
               end
               ST_ALOW:  enter_step = ST_AHIGH;
               ST_AHIGH: begin
                  if (rd_cmd) begin
                     rx_byte_in = shift_ff;
                  end else begin
                     nack_in = req_sda_in;
                  end
                  enter_step = ST_TAIL;
               end
               ST_PLOW:  enter_step = ST_PHIGH;
               ST_PHIGH: enter_step = ST_PREL;
               default: begin
                  // tail and release phases end the command
                  do_enter = 1'b0;
                  step_in  = ST_IDLE;
                  delay_in = '0;
                  done     = 1'b1;
               end
            endcase
         end
      end

      if (do_enter) begin
         step_in  = enter_step;
         delay_in = phase_len;
      end
   end

   assign rd_cmd = (cmd_ff == FUNC_READ_ACK) || (cmd_ff == FUNC_READ_NAK);

   // line drive on phase entry, from the updated command and shift byte
   always_comb begin
      scl_in     = scl_ff;
      sda_low_in = sda_low_ff;
      if (do_enter) begin
         case (enter_step)
            ST_REL:   sda_low_in = 1'b0;
            ST_SCLH:  scl_in = 1'b1;
            ST_SDAL:  sda_low_in = 1'b1;
            ST_SCLL:  scl_in = 1'b0;
            ST_BLOW: begin
               scl_in     = 1'b0;
               sda_low_in = (cmd_in == FUNC_READ_ACK || cmd_in == FUNC_READ_NAK)
                            ? 1'b0 : !shift_in[7];
            end
            ST_BHIGH: scl_in = 1'b1;
            ST_ALOW: begin
               scl_in     = 1'b0;
               sda_low_in = (cmd_in == FUNC_READ_ACK);
            end
            ST_AHIGH: scl_in = 1'b1;
            ST_TAIL, ST_PLOW: begin
               scl_in     = 1'b0;
               sda_low_in = 1'b1;
            end
            ST_PHIGH: scl_in = 1'b1;
            ST_PREL:  sda_low_in = 1'b0;
            default: begin
               scl_in     = scl_ff;
               sda_low_in = sda_low_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_IDLE;
         bit_count_ff <= 4'd0;
         shift_ff     <= 8'd0;
         delay_ff     <= '0;
         cmd_ff       <= FUNC_NONE;
         nack_ff      <= 1'b0;
         rx_byte_ff   <= 8'd0;
         scl_ff       <= 1'b1;
         sda_low_ff   <= 1'b0;
      end else if (accept) begin
         step_ff      <= step_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         delay_ff     <= delay_in;
         cmd_ff       <= cmd_in;
         nack_ff      <= nack_in;
         rx_byte_ff   <= rx_byte_in;
         scl_ff       <= scl_in;
         sda_low_ff   <= sda_low_in;
      end
   end

   // ---------------- result buffer ----------------
   always_comb begin
      res.scl_level    = scl_in;
      res.sda_pull_low = sda_low_in;
      res.busy_res     = (step_in != ST_IDLE);
      res.done_res     = done;
      res.read_byte    = rx_byte_in;
      res.nack         = nack_in;
   end

   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = res;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_stall        = skid_valid_ff;
   assign rsp_valid        = out_valid_ff;
   assign rsp_scl_level    = out_ff.scl_level;
   assign rsp_sda_pull_low = out_ff.sda_pull_low;
   assign rsp_busy_res     = out_ff.busy_res;
   assign rsp_done_res     = out_ff.done_res;
   assign rsp_read_byte    = out_ff.read_byte;
   assign rsp_nack         = out_ff.nack;

endmodule

`default_nettype wire

@@ hdl/i2cm_checker.sv @@
// Port-level checks for the I2C master bit sequencer, bound to the top level.
`default_nettype none

module i2cm_checker
   import i2cm_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic                   rsp_busy_res,
   input wire logic                   rsp_done_res,
   input wire logic                   rsp_scl_level,
   input wire logic [PADDR_WIDTH-1:0] paddr,
   input wire logic                   pready
);

   // a full skid register implies a held result in front of it
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   // completion pulse comes with busy already dropped
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> !rsp_busy_res)
      else $error("done reported while still busy");

   // a stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_busy_res)
                                    && $stable(rsp_scl_level) && $stable(rsp_done_res)))
      else $error("stalled result changed");

   // the configuration port never inserts wait states
   assert property (@(posedge clock) disable iff (reset)
      (paddr == paddr) |-> pready)
      else $error("pready dropped");

   // stall is only raised after an item has been taken
   assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid))
      else $error("stall raised without an accepted item");

endmodule

bind i2c_master_bit_sequencer i2cm_checker u_i2cm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_busy_res  (rsp_busy_res),
   .rsp_done_res  (rsp_done_res),
   .rsp_scl_level (rsp_scl_level),
   .paddr         (paddr),
   .pready        (pready)
);

`default_nettype wire

@@ bench/tb.sv @@
// Testbench for the I2C master bit sequencer: line drive prediction and per-item checks.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import i2cm_pkg::*;

   localparam logic [2:0] FUNC_UNUSED_6 = 3'd6;
   localparam logic [2:0] FUNC_UNUSED_7 = 3'd7;
   localparam logic [PADDR_WIDTH-1:0] HALF_PERIOD_ADDR = {REG_HALF_PERIOD, 2'b00};
   localparam int IDLE_PCT = 31;

   typedef enum logic [3:0] {
      STEP_IDLE, STEP_RELEASE, STEP_SCL_HIGH, STEP_SDA_LOW, STEP_SCL_LOW,
      STEP_BIT_LOW, STEP_BIT_HIGH, STEP_ACK_LOW, STEP_ACK_HIGH, STEP_TAIL,
      STEP_STOP_LOW, STEP_STOP_HIGH, STEP_STOP_RELEASE
   } line_step_e;

   // Tracks the SCL/SDA sequence tick by tick and holds the line drive expected per item.
   class i2c_line_predictor;
      logic [15:0] half_period = HALF_PERIOD_RESET;
      line_step_e  line_step = STEP_IDLE;
      logic [3:0]  bit_count = '0;
      logic [7:0]  shift_byte = '0;
      int unsigned ticks_left = 0;
      logic [2:0]  command = FUNC_NONE;
      logic        last_nack = 1'b0;
      logic [7:0]  rx_byte = '0;
      logic        scl_out = 1'b1;
      logic        sda_low = 1'b0;
      rsp_type     drive_expect_q[$];
      int          errors = 0;

      function void set_period(logic [15:0] value);
         half_period = value;
      endfunction

      function bit idle();
         return line_step == STEP_IDLE;
      endfunction

      function int pending();
         return drive_expect_q.size();
      endfunction

      function bit reading();
         return command == FUNC_READ_ACK || command == FUNC_READ_NAK;
      endfunction

      function void enter_phase(line_step_e st);
         line_step = st;
         case (st)
            STEP_RELEASE:      sda_low = 1'b0;
            STEP_SCL_HIGH:     scl_out = 1'b1;
            STEP_SDA_LOW:      sda_low = 1'b1;
            STEP_SCL_LOW:      scl_out = 1'b0;
            STEP_BIT_LOW: begin
               scl_out = 1'b0;
               sda_low = reading() ? 1'b0 : ~shift_byte[7];
            end
            STEP_BIT_HIGH:     scl_out = 1'b1;
            STEP_ACK_LOW: begin
               scl_out = 1'b0;
               sda_low = (command == FUNC_READ_ACK);
            end
            STEP_ACK_HIGH:     scl_out = 1'b1;
            STEP_TAIL: begin
               scl_out = 1'b0;
               sda_low = 1'b1;
            end
            STEP_STOP_LOW: begin
               scl_out = 1'b0;
               sda_low = 1'b1;
            end
            STEP_STOP_HIGH:    scl_out = 1'b1;
            STEP_STOP_RELEASE: sda_low = 1'b0;
            default: ;
         endcase
         // a zero half period still holds each phase for one tick
         ticks_left = (half_period == 0) ? 1 : half_period;
      endfunction

      function void take_tick(logic [2:0] func, logic [7:0] data, logic sda_in);
         rsp_type expect_drive;
         logic    done_now;
         done_now = 1'b0;
         if (line_step == STEP_IDLE) begin
            if (func >= FUNC_START && func <= FUNC_STOP) begin
               command = func;
               bit_count = '0;
               shift_byte = (func == FUNC_START || func == FUNC_WRITE) ? data : 8'h00;
               if (func == FUNC_START) enter_phase(STEP_RELEASE);
               else if (func == FUNC_STOP) enter_phase(STEP_STOP_LOW);
               else enter_phase(STEP_BIT_LOW);
            end
         end else begin
            ticks_left--;
            if (ticks_left == 0) begin
               case (line_step)
                  STEP_RELEASE:  enter_phase(STEP_SCL_HIGH);
                  STEP_SCL_HIGH: enter_phase(STEP_SDA_LOW);
                  STEP_SDA_LOW:  enter_phase(STEP_SCL_LOW);
                  STEP_SCL_LOW: begin
                     bit_count = '0;
                     enter_phase(STEP_BIT_LOW);
                  end
                  STEP_BIT_LOW:  enter_phase(STEP_BIT_HIGH);
                  STEP_BIT_HIGH: begin
                     shift_byte = {shift_byte[6:0], reading() ? sda_in : 1'b0};
                     bit_count++;
                     if (bit_count >= 8) enter_phase(STEP_ACK_LOW);
                     else enter_phase(STEP_BIT_LOW);
                  end
                  STEP_ACK_LOW:  enter_phase(STEP_ACK_HIGH);
                  STEP_ACK_HIGH: begin
                     if (reading()) rx_byte = shift_byte;
                     else last_nack = sda_in;
                     enter_phase(STEP_TAIL);
                  end
                  STEP_STOP_LOW:  enter_phase(STEP_STOP_HIGH);
                  STEP_STOP_HIGH: enter_phase(STEP_STOP_RELEASE);
                  default: begin
                     line_step = STEP_IDLE;
                     ticks_left = 0;
                     done_now = 1'b1;
                  end
               endcase
            end
         end
         expect_drive.scl_level    = scl_out;
         expect_drive.sda_pull_low = sda_low;
         expect_drive.busy_res     = (line_step != STEP_IDLE);
         expect_drive.done_res     = done_now;
         expect_drive.read_byte    = rx_byte;
         expect_drive.nack         = last_nack;
         drive_expect_q.push_back(expect_drive);
      endfunction

      function void match_field(string name, int unsigned exp_val, int unsigned got_val);
         if (exp_val != got_val) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
            errors++;
         end
      endfunction

      function void check_drive(rsp_type got);
         rsp_type exp_drive;
         if (drive_expect_q.size() == 0) begin
            $error("result item with no item outstanding");
            errors++;
            return;
         end
         exp_drive = drive_expect_q.pop_front();
         match_field("scl_level", exp_drive.scl_level, got.scl_level);
         match_field("sda_pull_low", exp_drive.sda_pull_low, got.sda_pull_low);
         match_field("busy_res", exp_drive.busy_res, got.busy_res);
         match_field("done_res", exp_drive.done_res, got.done_res);
         match_field("read_byte", exp_drive.read_byte, got.read_byte);
         match_field("nack", exp_drive.nack, got.nack);
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [2:0]             req_func = FUNC_NONE;
   logic [7:0]             req_data = '0;
   logic                   req_sda_in = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_scl_level;
   logic                   rsp_sda_pull_low;
   logic                   rsp_busy_res;
   logic                   rsp_done_res;
   logic [7:0]             rsp_read_byte;
   logic                   rsp_nack;
   logic                   psel = 1'b0;
   logic                   penable = 1'b0;
   logic                   pwrite = 1'b0;
   logic [PADDR_WIDTH-1:0] paddr = '0;
   logic [PDATA_WIDTH-1:0] pwdata = '0;
   logic [PDATA_WIDTH-1:0] prdata;
   logic                   pready;

   bit                     quiet = 1'b0;
   i2c_line_predictor      lines = new();

   i2c_master_bit_sequencer DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_data(req_data), .req_sda_in(req_sda_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_scl_level(rsp_scl_level),
      .rsp_sda_pull_low(rsp_sda_pull_low), .rsp_busy_res(rsp_busy_res),
      .rsp_done_res(rsp_done_res), .rsp_read_byte(rsp_read_byte), .rsp_nack(rsp_nack),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #6 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         lines.check_drive('{rsp_scl_level, rsp_sda_pull_low, rsp_busy_res,
                             rsp_done_res, rsp_read_byte, rsp_nack});
   end

   // called at a falling edge, returns at a falling edge
   task automatic push_item(input logic [2:0] func, input logic [7:0] data, input logic sda);
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_func   <= func;
      req_data   <= data;
      req_sda_in <= sda;
      do @(posedge clock); while (req_stall);
      lines.take_tick(func, data, sda);
      @(negedge clock);
   endtask

   task automatic write_half_period(input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= HALF_PERIOD_ADDR;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      lines.set_period(value[15:0]);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // issue one command, then keep ticking until the sequencer is back to idle
   task automatic run_command(input logic [2:0] func, input logic [7:0] data,
                              input logic sda, input logic [2:0] busy_func);
      push_item(func, data, sda);
      while (!lines.idle()) push_item(busy_func, data, sda);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (lines.pending() != 0) @(negedge clock);
   endtask

   task automatic random_traffic(input int count);
      logic [2:0] last_cmd;
      logic [2:0] func;
      int         roll;
      last_cmd = FUNC_NONE;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         if (!lines.idle()) begin
            // commands while busy must be ignored
            func = (roll < 15) ? 3'($urandom_range(0, 7)) : FUNC_NONE;
         end else if (roll < 10) begin
            case ($urandom_range(0, 2))
               0: func = FUNC_NONE;
               1: func = FUNC_UNUSED_6;
               default: func = FUNC_UNUSED_7;
            endcase
         end else begin
            roll = $urandom_range(0, 99);
            case (last_cmd)
               FUNC_START, FUNC_WRITE, FUNC_READ_ACK:
                  func = (roll < 45) ? FUNC_WRITE : (roll < 65) ? FUNC_READ_ACK :
                         (roll < 80) ? FUNC_READ_NAK : (roll < 88) ? FUNC_START : FUNC_STOP;
               FUNC_READ_NAK:
                  func = (roll < 70) ? FUNC_STOP : FUNC_START;
               default:
                  func = (roll < 85) ? FUNC_START : 3'($urandom_range(2, 5));
            endcase
            last_cmd = func;
         end
         push_item(func, 8'($urandom()), 1'($urandom()));
      end
      while (!lines.idle()) push_item(FUNC_NONE, 8'($urandom()), 1'($urandom()));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: every command with one-tick phases
      write_half_period(32'h0000_0000);
      run_command(FUNC_START, 8'hFF, 1'b1, FUNC_NONE);
      run_command(FUNC_WRITE, 8'h00, 1'b0, FUNC_START);
      run_command(FUNC_READ_ACK, 8'hFF, 1'b1, FUNC_NONE);
      run_command(FUNC_READ_NAK, 8'h00, 1'b0, FUNC_UNUSED_7);
      run_command(FUNC_UNUSED_6, 8'hA5, 1'b1, FUNC_NONE);
      run_command(FUNC_UNUSED_7, 8'h5A, 1'b0, FUNC_NONE);
      run_command(FUNC_NONE, 8'hFF, 1'b1, FUNC_NONE);
      run_command(FUNC_STOP, 8'hFF, 1'b1, FUNC_WRITE);
      settle();

      // upper data bits are outside the register
      write_half_period(32'hFFFF_0001);
      random_traffic(250);
      settle();
      write_half_period(32'd2);
      random_traffic(250);
      settle();
      write_half_period(32'($urandom_range(3, 5)));
      random_traffic(250);
      settle();

      // a long stretch back to back with no idling on either side
      quiet = 1'b1;
      write_half_period(32'd3);
      random_traffic(100);
      settle();

      repeat (8) @(negedge clock);
      if (lines.errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
